FILE: rtl/pip_pkg.sv
// shared types, widths and helpers for the point-in-polygon ray-cast block
`timescale 1ns / 1ps

package pip_pkg;

    // width of every coordinate field and of the far-x register on the ports
    localparam int FIELD_W = 16;

    // coordinates are taken from the low COORD_BITS bits of each field
    localparam int COORD_BITS = 16;

    // widths of the edge differences and of their products
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;

    // far-x register value after reset
    localparam logic signed [FIELD_W-1:0] RAY_FAR_X_RESET = -16'sd1000;

    // fewest edges that make a polygon
    localparam logic [1:0] MIN_EDGES = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]     t_prod;

    // one accepted input item as it sits in the input register
    typedef struct packed {
        logic [FIELD_W-1:0] query_x;
        logic [FIELD_W-1:0] query_y;
        logic [FIELD_W-1:0] edge_start_x;
        logic [FIELD_W-1:0] edge_start_y;
        logic [FIELD_W-1:0] edge_end_x;
        logic [FIELD_W-1:0] edge_end_y;
        logic               last_edge;
    } t_edge_in;

    // products and flags handed from the product stage to the result stage
    typedef struct packed {
        t_prod prod_ry_ex;   // (py - sy) * (ex - sx)
        t_prod prod_ey_px;   // (ey - sy) * (px - sx)
        t_prod prod_ey_ox;   // (ey - sy) * (ox - sx)
        logic  opp_ray;      // edge endpoints strictly on both sides of the ray line
        logic  box_query;    // query point inside the edge bounding box
        logic  box_far;      // ray far point inside the edge bounding box
        logic  end_on_ray;   // an endpoint lies on the ray segment
        logic  vertex;       // an endpoint on the ray row at or right of the point
        logic  last_edge;
    } t_edge_prep;

    // low COORD_BITS bits of a field as a signed coordinate
    function automatic t_coord to_coord(input logic [FIELD_W-1:0] f);
        logic [FIELD_W+COORD_BITS-1:0] ext;
        ext = {{COORD_BITS{1'b0}}, f};
        return t_coord'(ext[COORD_BITS-1:0]);
    endfunction

    // v lies between a and b, inclusive, in either order
    function automatic logic between(input t_coord v, input t_coord a, input t_coord b);
        return ((v >= a) && (v <= b)) || ((v >= b) && (v <= a));
    endfunction

endpackage

FILE: rtl/pip_edge_prep.sv
// product stage: edge differences, cross products and bounding-box flags
`timescale 1ns / 1ps

module pip_edge_prep import pip_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic signed [FIELD_W-1:0] i_ray_far_x,
    input  logic                      i_valid,
    input  t_edge_in                  i_edge,
    output logic                      o_ready,
    output logic                      o_valid,
    output t_edge_prep                o_prep,
    input  logic                      i_ready
);

    t_coord px, py, sx, sy, ex, ey, ox;
    logic signed [DIFF_W-1:0] d_ry, d_ex, d_ey, d_px, d_ox;
    logic sy_above, sy_below, ey_above, ey_below, ox_right, ox_left;
    logic d3_pos, d3_neg, d4_pos, d4_neg;
    logic y_in_box;
    t_edge_prep n_prep;
    logic r_valid;
    t_edge_prep r_prep;

    // coordinates of this edge and query
    always_comb begin
        px = to_coord(i_edge.query_x);
        py = to_coord(i_edge.query_y);
        sx = to_coord(i_edge.edge_start_x);
        sy = to_coord(i_edge.edge_start_y);
        ex = to_coord(i_edge.edge_end_x);
        ey = to_coord(i_edge.edge_end_y);
        ox = to_coord(i_ray_far_x);
    end

    // edge-relative differences, exact at one bit wider
    always_comb begin
        d_ry = DIFF_W'(py) - DIFF_W'(sy);
        d_ex = DIFF_W'(ex) - DIFF_W'(sx);
        d_ey = DIFF_W'(ey) - DIFF_W'(sy);
        d_px = DIFF_W'(px) - DIFF_W'(sx);
        d_ox = DIFF_W'(ox) - DIFF_W'(sx);
    end

    // endpoint orientations against the ray line reduce to sign products
    always_comb begin
        sy_above = sy > py;
        sy_below = sy < py;
        ey_above = ey > py;
        ey_below = ey < py;
        ox_right = ox > px;
        ox_left  = ox < px;
        d3_pos   = (sy_above && ox_right) || (sy_below && ox_left);
        d3_neg   = (sy_above && ox_left) || (sy_below && ox_right);
        d4_pos   = (ey_above && ox_right) || (ey_below && ox_left);
        d4_neg   = (ey_above && ox_left) || (ey_below && ox_right);
        y_in_box = between(py, sy, ey);
    end

    // next contents of the product register
    always_comb begin
        n_prep.prod_ry_ex = t_prod'(d_ry) * t_prod'(d_ex);
        n_prep.prod_ey_px = t_prod'(d_ey) * t_prod'(d_px);
        n_prep.prod_ey_ox = t_prod'(d_ey) * t_prod'(d_ox);
        n_prep.opp_ray    = (d3_pos && d4_neg) || (d3_neg && d4_pos);
        n_prep.box_query  = between(px, sx, ex) && y_in_box;
        n_prep.box_far    = between(ox, sx, ex) && y_in_box;
        n_prep.end_on_ray = (!d3_pos && !d3_neg && between(sx, px, ox) && (sy == py)) ||
                            (!d4_pos && !d4_neg && between(ex, px, ox) && (ey == py));
        n_prep.vertex     = ((sy == py) && (sx >= px)) || ((ey == py) && (ex >= px));
        n_prep.last_edge  = i_edge.last_edge;
    end

    assign o_ready = !r_valid || i_ready;

    // product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_prep <= n_prep;
        end
    end

    assign o_valid = r_valid;
    assign o_prep  = r_prep;

endmodule

FILE: rtl/pip_crossing.sv
// result stage: orientation signs, crossing parity, edge count and result register
`timescale 1ns / 1ps

module pip_crossing import pip_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_edge_prep i_prep,
    output logic       o_ready,
    output logic       o_out_valid,
    output logic       o_is_inside,
    output logic       o_too_few_edges,
    input  logic       i_out_ready
);

    logic d1_pos, d1_neg, d1_zero, d2_pos, d2_neg, d2_zero;
    logic hit, flip, out_free, take;
    logic n_parity, few;
    logic [1:0] n_count;
    logic r_parity;
    logic [1:0] r_edges_seen;
    logic r_out_valid, r_is_inside, r_too_few;

    // signs of the edge-line orientations d1 and d2
    always_comb begin
        d1_pos  = i_prep.prod_ry_ex > i_prep.prod_ey_px;
        d1_neg  = i_prep.prod_ry_ex < i_prep.prod_ey_px;
        d1_zero = !d1_pos && !d1_neg;
        d2_pos  = i_prep.prod_ry_ex > i_prep.prod_ey_ox;
        d2_neg  = i_prep.prod_ry_ex < i_prep.prod_ey_ox;
        d2_zero = !d2_pos && !d2_neg;
    end

    // segment intersection, then the vertex rule
    always_comb begin
        hit  = (((d1_pos && d2_neg) || (d1_neg && d2_pos)) && i_prep.opp_ray) ||
               (d1_zero && i_prep.box_query) ||
               (d2_zero && i_prep.box_far) ||
               i_prep.end_on_ray;
        flip = hit && !i_prep.vertex;
    end

    // an edge without the last flag never waits on the result register
    assign out_free = !r_out_valid || i_out_ready;
    assign o_ready  = !i_valid || !i_prep.last_edge || out_free;
    assign take     = i_valid && o_ready;

    // updated parity and saturating count for this edge
    always_comb begin
        n_parity = r_parity ^ flip;
        n_count  = (r_edges_seen == MIN_EDGES) ? r_edges_seen : r_edges_seen + 2'd1;
        few      = n_count < MIN_EDGES;
    end

    // running state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity     <= 1'b0;
            r_edges_seen <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take && i_prep.last_edge) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (take) begin
                if (i_prep.last_edge) begin
                    r_parity     <= 1'b0;
                    r_edges_seen <= 2'd0;
                end else begin
                    r_parity     <= n_parity;
                    r_edges_seen <= n_count;
                end
            end
        end
        if (take && i_prep.last_edge) begin
            r_is_inside <= !few && n_parity;
            r_too_few   <= few;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_inside     = r_is_inside;
    assign o_too_few_edges = r_too_few;

endmodule

FILE: rtl/point_in_polygon_ray_cast.sv
// top level of the point-in-polygon ray-cast edge tester
`timescale 1ns / 1ps

// Each transfer on the input channel carries the query point and one polygon edge; the
// block accepts one edge every clock cycle unless the output stalls it, and keeps a crossing
// parity and an edge count across edges of the same query. The edge marked last_edge
// produces one result transfer after it has passed the input register, the cross-product
// register and the result register. Edges without last_edge produce no result. While a
// result waits on the output, edges keep flowing until a further last edge reaches the
// result stage. ray_far_x is written through i_cfg_we / i_cfg_wdata and should only
// change while no edge is in flight.

module point_in_polygon_ray_cast import pip_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic signed [FIELD_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [FIELD_W-1:0] i_query_x,
    input  logic signed [FIELD_W-1:0] i_query_y,
    input  logic signed [FIELD_W-1:0] i_edge_start_x,
    input  logic signed [FIELD_W-1:0] i_edge_start_y,
    input  logic signed [FIELD_W-1:0] i_edge_end_x,
    input  logic signed [FIELD_W-1:0] i_edge_end_y,
    input  logic                      i_last_edge,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_is_inside,
    output logic                      o_too_few_edges
);

    logic signed [FIELD_W-1:0] r_ray_far_x;
    logic       r_in_valid;
    t_edge_in   r_in;
    t_edge_in   n_in;
    logic       prep_ready, prep_valid, cross_ready;
    t_edge_prep prep;

    // far-x configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray_far_x <= RAY_FAR_X_RESET;
        end else if (i_cfg_we) begin
            r_ray_far_x <= i_cfg_wdata;
        end
    end

    // input register
    always_comb begin
        n_in.query_x      = i_query_x;
        n_in.query_y      = i_query_y;
        n_in.edge_start_x = i_edge_start_x;
        n_in.edge_start_y = i_edge_start_y;
        n_in.edge_end_x   = i_edge_end_x;
        n_in.edge_end_y   = i_edge_end_y;
        n_in.last_edge    = i_last_edge;
    end

    assign o_in_ready = !r_in_valid || prep_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= n_in;
        end
    end

    // cross products and box flags
    pip_edge_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ray_far_x (r_ray_far_x),
        .i_valid     (r_in_valid),
        .i_edge      (r_in),
        .o_ready     (prep_ready),
        .o_valid     (prep_valid),
        .o_prep      (prep),
        .i_ready     (cross_ready)
    );

    // crossing decision, parity and result
    pip_crossing u_cross (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (prep_valid),
        .i_prep          (prep),
        .o_ready         (cross_ready),
        .o_out_valid     (o_out_valid),
        .o_is_inside     (o_is_inside),
        .o_too_few_edges (o_too_few_edges),
        .i_out_ready     (i_out_ready)
    );

endmodule

FILE: rtl/pip_checker.sv
// port-level checks for the point-in-polygon ray-cast block, bound to the top level
`timescale 1ns / 1ps

module pip_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_is_inside,
    input logic o_too_few_edges
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a short polygon is never reported inside
    a_few_not_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_inside && o_too_few_edges))
        else $error("inside reported with too few edges");

    // a free output lets the pipeline take an edge
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output free");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_is_inside) && $stable(o_too_few_edges)))
        else $error("result changed while stalled");

endmodule

bind point_in_polygon_ray_cast pip_checker u_pip_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_is_inside     (o_is_inside),
    .o_too_few_edges (o_too_few_edges)
);
